FILE: rtl/rbj_pkg.sv
// Shared types and constants of the range/bearing Jacobian unit.
// Depends on nothing; used by rbj_pipe and range_bearing_jacobian_unit.
package rbj_pkg;

  localparam int DW          = 32;   // Q16.16 data width
  localparam int FRAC        = 16;
  localparam int RANGE_W     = 31;
  localparam int BEARING_W   = 19;
  localparam int CORDIC_N    = 24;
  localparam int NSTAGE      = 60;   // pipeline depth
  localparam int IN_W        = 9 * DW;
  localparam int OUT_W       = 312;  // 306 used bits padded to bytes
  localparam int CFG_IDX_W   = 8;

  localparam logic signed [27:0] PI_Q24     = 28'sd52707179;
  localparam logic signed [34:0] PI_Q16     = 35'sd205887;
  localparam logic signed [34:0] TWO_PI_Q16 = 35'sd411774;
  // 8192 * 2*pi in Q16.16, makes the angle difference non-negative
  localparam logic signed [34:0] MOD_BIAS   = 35'sd3373252608;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOISE_00 = 8'd0,
    REG_NOISE_01 = 8'd1,
    REG_NOISE_10 = 8'd2,
    REG_NOISE_11 = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DW-1:0] n00;
    logic signed [DW-1:0] n01;
    logic signed [DW-1:0] n10;
    logic signed [DW-1:0] n11;
  } noise_t;

  typedef struct packed {
    logic signed [DW-1:0] vx;
    logic signed [DW-1:0] vy;
    logic signed [DW-1:0] hd;
    logic signed [DW-1:0] lx;
    logic signed [DW-1:0] ly;
    logic signed [DW-1:0] p00;
    logic signed [DW-1:0] p01;
    logic signed [DW-1:0] p10;
    logic signed [DW-1:0] p11;
  } in_t;

  // Everything one item carries down the pipeline
  typedef struct packed {
    logic                 degen;
    logic                 dxn;
    logic                 dyn;
    logic [32:0]          ax;
    logic [32:0]          ay;
    logic signed [DW-1:0] hd;
    logic signed [DW-1:0] p00;
    logic signed [DW-1:0] p01;
    logic signed [DW-1:0] p10;
    logic signed [DW-1:0] p11;
    logic [65:0]          mxx;
    logic [65:0]          myy;
    logic [65:0]          d2;
    logic [35:0]          sq_rem;
    logic [33:0]          sq_root;
    logic [16:0]          qx;
    logic [16:0]          qy;
    logic [33:0]          rx;
    logic [33:0]          ry;
    logic [31:0]          bx;
    logic [31:0]          by;
    logic [65:0]          brx;
    logic [65:0]          bry;
    logic                 ovx;
    logic                 ovy;
    logic signed [45:0]   cx;
    logic signed [45:0]   cy;
    logic signed [27:0]   cz;
    logic signed [34:0]   bv;
    logic signed [BEARING_W-1:0] brg;
    logic [RANGE_W-1:0]   rng;
    logic signed [DW-1:0] h00;
    logic signed [DW-1:0] h01;
    logic signed [DW-1:0] h10;
    logic signed [DW-1:0] h11;
    logic signed [63:0]   m0;
    logic signed [63:0]   m1;
    logic signed [63:0]   m2;
    logic signed [63:0]   m3;
    logic signed [63:0]   m4;
    logic signed [63:0]   m5;
    logic signed [63:0]   m6;
    logic signed [63:0]   m7;
    logic signed [DW-1:0] t00;
    logic signed [DW-1:0] t01;
    logic signed [DW-1:0] t10;
    logic signed [DW-1:0] t11;
    logic signed [DW-1:0] s00;
    logic signed [DW-1:0] s01;
    logic signed [DW-1:0] s10;
    logic signed [DW-1:0] s11;
  } stage_t;

endpackage

FILE: rtl/rbj_pipe.sv
// Sixty-stage datapath: square root, dividers, CORDIC, angle wrap and the
// innovation covariance products. Depends on rbj_pkg.
module rbj_pipe (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rbj_pkg::in_t    in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rbj_pkg::stage_t out_o,
  input  rbj_pkg::noise_t noise_i
);
  import rbj_pkg::*;

  function automatic logic signed [27:0] atan_q24(input int i);
    logic signed [27:0] v;
    case (i)
      0: v = 28'sd13176795;  1: v = 28'sd7778716;  2: v = 28'sd4110060;
      3: v = 28'sd2086331;   4: v = 28'sd1047214;  5: v = 28'sd524117;
      6: v = 28'sd262123;    7: v = 28'sd131069;   8: v = 28'sd65536;
      9: v = 28'sd32768;    10: v = 28'sd16384;   11: v = 28'sd8192;
      12: v = 28'sd4096;    13: v = 28'sd2048;    14: v = 28'sd1024;
      15: v = 28'sd512;     16: v = 28'sd256;     17: v = 28'sd128;
      18: v = 28'sd64;      19: v = 28'sd32;      20: v = 28'sd16;
      21: v = 28'sd8;       22: v = 28'sd4;       23: v = 28'sd2;
      default: v = 28'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [DW-1:0] sat_w(input logic signed [64:0] v);
    logic signed [DW-1:0] r;
    if (v > 65'sd2147483647) r = 32'sh7fffffff;
    else if (v < -65'sd2147483648) r = 32'sh80000000;
    else r = v[DW-1:0];
    return r;
  endfunction

  // floor((a + b) / 2^16), saturated
  function automatic logic signed [DW-1:0] fx_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] sum;
    sum = 65'(a) + 65'(b);
    return sat_w(sum >>> FRAC);
  endfunction

  // quotient of mag * 2^32 / d2, signed and clipped
  function automatic logic signed [DW-1:0] ratio(input logic [31:0] q,
                                                  input logic ov, input logic neg);
    logic [32:0]        lim;
    logic [32:0]        qq;
    logic signed [32:0] sv;
    lim = neg ? 33'h100000000 >> 1 : (33'h100000000 >> 1) - 33'd1;
    qq  = {1'b0, q};
    if (ov || qq > lim) qq = lim;
    sv  = neg ? -$signed(qq) : $signed(qq);
    return sv[DW-1:0];
  endfunction

  function automatic stage_t stage_fn(input stage_t a, input int s, input noise_t rn);
    stage_t              r;
    logic [45:0]         mx;
    logic [67:0]         d2x;
    logic [37:0]         rem_n;
    logic [37:0]         trial;
    logic [66:0]         b2;
    logic [34:0]         r2;
    logic signed [45:0]  xs;
    logic signed [45:0]  ys;
    logic signed [27:0]  z;
    logic signed [34:0]  mstep;
    logic                negy;
    int                  k;
    int                  j;
    r = a;
    // squares of the offsets, then their sum
    if (s == 2) begin
      r.mxx = {33'b0, a.ax} * {33'b0, a.ax};
      r.myy = {33'b0, a.ay} * {33'b0, a.ay};
    end
    if (s == 3) r.d2 = a.mxx + a.myy;
    // CORDIC input normalization, binary shift search
    if (s >= 2 && s <= 7) begin
      k  = 32 >> (s - 2);
      mx = (a.cx > a.cy) ? a.cx : a.cy;
      if ((mx >> (41 - k)) == 46'd0) begin
        r.cx = a.cx <<< k;
        r.cy = a.cy <<< k;
      end
    end
    // digit-by-digit square root, two radicand bits a stage
    if (s >= 4 && s <= 37) begin
      j     = s - 4;
      d2x   = {2'b00, a.d2};
      rem_n = {a.sq_rem, d2x[67-2*j -: 2]};
      trial = {2'b00, a.sq_root, 2'b01};
      if (rem_n >= trial) begin
        r.sq_rem  = 36'(rem_n - trial);
        r.sq_root = {a.sq_root[32:0], 1'b1};
      end else begin
        r.sq_rem  = rem_n[35:0];
        r.sq_root = {a.sq_root[32:0], 1'b0};
      end
    end
    // bearing Jacobian dividers by d^2
    if (s == 4) begin
      r.ovx = ({33'b0, a.ax} >= a.d2);
      r.ovy = ({33'b0, a.ay} >= a.d2);
      r.brx = {33'b0, a.ax};
      r.bry = {33'b0, a.ay};
      r.bx  = '0;
      r.by  = '0;
    end
    if (s >= 5 && s <= 36) begin
      b2 = {a.brx, 1'b0};
      if (b2 >= {1'b0, a.d2}) begin
        r.brx = 66'(b2 - {1'b0, a.d2});
        r.bx  = {a.bx[30:0], 1'b1};
      end else begin
        r.brx = b2[65:0];
        r.bx  = {a.bx[30:0], 1'b0};
      end
      b2 = {a.bry, 1'b0};
      if (b2 >= {1'b0, a.d2}) begin
        r.bry = 66'(b2 - {1'b0, a.d2});
        r.by  = {a.by[30:0], 1'b1};
      end else begin
        r.bry = b2[65:0];
        r.by  = {a.by[30:0], 1'b0};
      end
    end
    // CORDIC vectoring
    if (s >= 8 && s <= 7 + CORDIC_N) begin
      j  = s - 8;
      xs = a.cx >>> j;
      ys = a.cy >>> j;
      if (a.cy >= 0) begin
        r.cx = a.cx + ys;
        r.cy = a.cy - xs;
        r.cz = a.cz + atan_q24(j);
      end else begin
        r.cx = a.cx - ys;
        r.cy = a.cy + xs;
        r.cz = a.cz - atan_q24(j);
      end
    end
    // quadrant restore
    if (s == 32) begin
      z = a.cz;
      if (a.dxn) z = PI_Q24 - z;
      if (a.dyn) z = -z;
      r.cz = z;
    end
    // round to Q16.16, take off heading, bias positive
    if (s == 33) begin
      z    = (a.cz + 28'sd128) >>> 8;
      r.bv = 35'(z) - 35'(a.hd) + MOD_BIAS;
    end
    // restoring reduction modulo 2*pi
    if (s >= 34 && s <= 47) begin
      j     = 47 - s;
      mstep = TWO_PI_Q16 <<< j;
      if (a.bv >= mstep) r.bv = a.bv - mstep;
    end
    if (s == 48) begin
      r.brg = (a.bv > PI_Q16) ? BEARING_W'(a.bv - TWO_PI_Q16) : BEARING_W'(a.bv);
    end
    // range Jacobian dividers by d
    if (s == 38) begin
      if ({1'b0, a.ax} >= a.sq_root) begin
        r.qx = 17'd1;
        r.rx = 34'({1'b0, a.ax} - a.sq_root);
      end else begin
        r.qx = 17'd0;
        r.rx = {1'b0, a.ax};
      end
      if ({1'b0, a.ay} >= a.sq_root) begin
        r.qy = 17'd1;
        r.ry = 34'({1'b0, a.ay} - a.sq_root);
      end else begin
        r.qy = 17'd0;
        r.ry = {1'b0, a.ay};
      end
    end
    if (s >= 39 && s <= 54) begin
      r2 = {a.rx, 1'b0};
      if (r2 >= {1'b0, a.sq_root}) begin
        r.rx = 34'(r2 - {1'b0, a.sq_root});
        r.qx = {a.qx[15:0], 1'b1};
      end else begin
        r.rx = r2[33:0];
        r.qx = {a.qx[15:0], 1'b0};
      end
      r2 = {a.ry, 1'b0};
      if (r2 >= {1'b0, a.sq_root}) begin
        r.ry = 34'(r2 - {1'b0, a.sq_root});
        r.qy = {a.qy[15:0], 1'b1};
      end else begin
        r.ry = r2[33:0];
        r.qy = {a.qy[15:0], 1'b0};
      end
    end
    // signed Jacobian entries
    if (s == 55) begin
      r.h00 = a.dxn ? -$signed({15'b0, a.qx}) : $signed({15'b0, a.qx});
      r.h01 = a.dyn ? -$signed({15'b0, a.qy}) : $signed({15'b0, a.qy});
      negy  = !a.dyn && (a.ay != 33'd0);
      r.h10 = ratio(a.by, a.ovy, negy);
      r.h11 = ratio(a.bx, a.ovx, a.dxn);
    end
    // T = Hf * P
    if (s == 56) begin
      r.m0 = a.h00 * a.p00;  r.m1 = a.h01 * a.p10;
      r.m2 = a.h00 * a.p01;  r.m3 = a.h01 * a.p11;
      r.m4 = a.h10 * a.p00;  r.m5 = a.h11 * a.p10;
      r.m6 = a.h10 * a.p01;  r.m7 = a.h11 * a.p11;
    end
    if (s == 57) begin
      r.t00 = fx_sum(a.m0, a.m1);  r.t01 = fx_sum(a.m2, a.m3);
      r.t10 = fx_sum(a.m4, a.m5);  r.t11 = fx_sum(a.m6, a.m7);
    end
    // S = T * Hf'
    if (s == 58) begin
      r.m0 = a.t00 * a.h00;  r.m1 = a.t01 * a.h01;
      r.m2 = a.t00 * a.h10;  r.m3 = a.t01 * a.h11;
      r.m4 = a.t10 * a.h00;  r.m5 = a.t11 * a.h01;
      r.m6 = a.t10 * a.h10;  r.m7 = a.t11 * a.h11;
    end
    if (s == 59) begin
      r.s00 = fx_sum(a.m0, a.m1);  r.s01 = fx_sum(a.m2, a.m3);
      r.s10 = fx_sum(a.m4, a.m5);  r.s11 = fx_sum(a.m6, a.m7);
    end
    // add noise, clip range, clear a degenerate result
    if (s == NSTAGE) begin
      r.s00 = sat_w(65'(a.s00) + 65'(rn.n00));
      r.s01 = sat_w(65'(a.s01) + 65'(rn.n01));
      r.s10 = sat_w(65'(a.s10) + 65'(rn.n10));
      r.s11 = sat_w(65'(a.s11) + 65'(rn.n11));
      r.rng = (a.sq_root > 34'h07fffffff) ? {RANGE_W{1'b1}} : a.sq_root[RANGE_W-1:0];
      if (a.degen) begin
        r.rng = '0;  r.brg = '0;
        r.h00 = '0;  r.h01 = '0;  r.h10 = '0;  r.h11 = '0;
        r.s00 = '0;  r.s01 = '0;  r.s10 = '0;  r.s11 = '0;
      end
    end
    return r;
  endfunction

  stage_t             st_q [1:NSTAGE];
  stage_t             st1_d;
  logic [NSTAGE:1]    vld_q;
  logic               adv;
  logic signed [32:0] dx;
  logic signed [32:0] dy;

  // whole pipe moves unless the output beat is held
  assign adv         = !vld_q[NSTAGE] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[NSTAGE];
  assign out_o       = st_q[NSTAGE];

  // first stage: offsets, magnitudes and signs
  always_comb begin
    dx          = 33'(in_i.lx) - 33'(in_i.vx);
    dy          = 33'(in_i.ly) - 33'(in_i.vy);
    st1_d       = '0;
    st1_d.dxn   = dx[32];
    st1_d.dyn   = dy[32];
    st1_d.ax    = dx[32] ? 33'(-dx) : 33'(dx);
    st1_d.ay    = dy[32] ? 33'(-dy) : 33'(dy);
    st1_d.degen = (dx == 33'sd0) && (dy == 33'sd0);
    st1_d.cx    = $signed({13'b0, st1_d.ax});
    st1_d.cy    = $signed({13'b0, st1_d.ay});
    st1_d.hd    = in_i.hd;
    st1_d.p00   = in_i.p00;
    st1_d.p01   = in_i.p01;
    st1_d.p10   = in_i.p10;
    st1_d.p11   = in_i.p11;
  end

  always_ff @(posedge clk_i) begin
    if (adv) st_q[1] <= st1_d;
  end

  for (genvar s = 2; s <= NSTAGE; s++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (adv) st_q[s] <= stage_fn(st_q[s-1], s, noise_i);
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTAGE-1:1], in_valid_i};
    end
  end

endmodule

FILE: rtl/range_bearing_jacobian_unit.sv
// Top level of the range/bearing observation Jacobian unit: stream ports,
// noise registers and beat packing. Depends on rbj_pkg and rbj_pipe.
//
// Takes one vehicle pose plus one landmark with its 2x2 covariance per beat
// and returns range, wrapped bearing, the landmark Jacobian and the
// innovation covariance Hf*P*Hf' + R; range unsigned Q15.16, bearing signed
// Q3.16, rest signed Q16.16. A new beat is taken every clock unless output
// backpressure stalls the whole pipeline. Stages: three front ones
// (offsets, squares, their sum), the 34-step square root, the 17-step range
// divider, one sign stage, the four multiply/sum stages of the covariance
// product and the noise add. The user must write the noise registers R via
// the cfg port while no beat is in flight; the block does not enforce it.
module range_bearing_jacobian_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // vehicle_x, vehicle_y, vehicle_heading, landmark_x, landmark_y,
  // cov_00, cov_01, cov_10, cov_11 (32 bits each)
  input  logic [rbj_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // predicted_range (31), predicted_bearing (19), jac_range_x, jac_range_y,
  // jac_bearing_x, jac_bearing_y, innov_00, innov_01, innov_10, innov_11
  // (32 each), zero pad (6)
  output logic [rbj_pkg::OUT_W-1:0]     m_axis_tdata,
  // degenerate
  output logic [0:0]                    m_axis_tuser,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rbj_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rbj_pkg::DW-1:0]        cfg_data_i
);
  import rbj_pkg::*;

  noise_t noise_q;
  in_t    in_item;
  stage_t res;

  // noise registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_NOISE_00: noise_q.n00 <= cfg_data_i;
        REG_NOISE_01: noise_q.n01 <= cfg_data_i;
        REG_NOISE_10: noise_q.n10 <= cfg_data_i;
        REG_NOISE_11: noise_q.n11 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // unpack input beat
  assign in_item.vx  = s_axis_tdata[0*DW +: DW];
  assign in_item.vy  = s_axis_tdata[1*DW +: DW];
  assign in_item.hd  = s_axis_tdata[2*DW +: DW];
  assign in_item.lx  = s_axis_tdata[3*DW +: DW];
  assign in_item.ly  = s_axis_tdata[4*DW +: DW];
  assign in_item.p00 = s_axis_tdata[5*DW +: DW];
  assign in_item.p01 = s_axis_tdata[6*DW +: DW];
  assign in_item.p10 = s_axis_tdata[7*DW +: DW];
  assign in_item.p11 = s_axis_tdata[8*DW +: DW];

  rbj_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_i        (in_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res),
    .noise_i     (noise_q)
  );

  // pack result beat
  assign m_axis_tdata = {6'b0, res.s11, res.s10, res.s01, res.s00,
                         res.h11, res.h10, res.h01, res.h00,
                         res.brg, res.rng};
  assign m_axis_tuser = res.degen;

endmodule
